// ===== sv/assert_macros.svh =====
// Assertion macros shared by the profiler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`endif

// ===== sv/cstp_pkg.sv =====
// Package with shared types and constants of the call-stack profiler.
package cstp_pkg;
  localparam int unsigned StackDepth = 256;
  localparam int unsigned PtrW = $clog2(StackDepth);
  localparam int unsigned DepthW = PtrW + 1;
  localparam logic [19:0] UsPerSecond = 20'd1000000;
  localparam logic [31:0] FreqReset = 32'd10000000;

  typedef enum logic [1:0] {
    CFG_TIME_EN = 2'd0,
    CFG_MEM_EN  = 2'd1,
    CFG_FREQ    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_REPORTED  = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_MUL,
    BK_DIV,
    BK_FIN,
    BK_OUT
  } bk_state_e;

  // Classified event passed from front to back.
  typedef struct packed {
    logic        mode;
    logic [62:0] timestamp;
    logic [31:0] total_bytes;
  } evt_t;

  typedef struct packed {
    status_e            status;
    logic signed [63:0] self_time;
    logic [31:0]        mem_delta;
    logic [DepthW-1:0]  depth;
  } res_t;
endpackage

// ===== sv/call_stack_self_time_profiler.sv =====
// Top level of the call-stack self-time profiler.
// Usage:
//   s_axis carries events: tuser = mode (0 call, 1 return); tdata from bit 0
//   upward = timestamp 62:0, total_bytes 94:63. m_axis returns one result per
//   event: tuser = status; tdata = self_time 63:0, mem_delta 95:64, depth 104:96.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle:
//   index 0 time enable, 1 memory enable, 2 tick frequency.
// Steps: a call or a stack error goes from the read state straight to the finish
//   state and the result register; a return first passes the scaling multiply
//   and the bit-serial 64-bit divider (setup, then one quotient bit a cycle).
// Flow: one event in flight in the back part, which takes no new event until
//   its result is taken; a two-entry input queue keeps taking transfers while
//   a result waits.
// Reset: stack empties, registers go to their defaults (frequency 10 MHz),
//   frame contents stay undefined until written.
// Stall: when m_axis_tready is low the result holds and the back part waits;
//   the queue fills and then s_axis_tready drops.
module call_stack_self_time_profiler import cstp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // timestamp[62:0], total_bytes[31:0]
  input  logic [0:0]   s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,  // self_time[63:0], mem_delta[31:0], depth[8:0]
  output logic [2:0]   m_axis_tuser   // status[2:0]
);
  logic        time_en_q, mem_en_q;
  logic [31:0] freq_q;
  evt_t        in_evt, q_evt;
  logic        q_valid, q_ready;
  res_t        res;

  // Config registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_en_q <= 1'b0; mem_en_q <= 1'b0; freq_q <= FreqReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIME_EN: time_en_q <= cfg_data_i[0];
        CFG_MEM_EN:  mem_en_q  <= cfg_data_i[0];
        CFG_FREQ:    freq_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_evt.mode        = s_axis_tuser[0];
  assign in_evt.timestamp   = s_axis_tdata[62:0];
  assign in_evt.total_bytes = s_axis_tdata[94:63];

  cstp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_evt_i(in_evt),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_evt_o(q_evt)
  );

  cstp_back u_back (
    .clk_i, .rst_ni,
    .time_en_i(time_en_q), .mem_en_i(mem_en_q), .freq_i(freq_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_evt_i(q_evt),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {7'd0, res.depth, res.mem_delta, res.self_time};
  assign m_axis_tuser = res.status;
endmodule

// ===== sv/cstp_front.sv =====
// Front part: input skid queue of two entries.
module cstp_front import cstp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  evt_t in_evt_i,
  output logic q_valid_o,
  input  logic q_ready_i,
  output evt_t q_evt_o
);
  evt_t        mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_evt_o    = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_evt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`include "assert_macros.svh"
  `ASSERT_CLK(a_cnt_range, cnt_q != 2'd3, "queue count out of range")
  `ASSERT_CLK(a_no_push_full, cnt_q == 2'd2 |-> !push, "push into full queue")
  `ASSERT_CLK(a_cnt_track, $past(push) && !$past(pop) |-> cnt_q == $past(cnt_q) + 2'd1,
              "queue count lost a push")
endmodule

// ===== sv/cstp_back.sv =====
// Back part: stack frames, scaling multiply, serial divide and result register.
module cstp_back import cstp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        time_en_i,
  input  logic        mem_en_i,
  input  logic [31:0] freq_i,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  evt_t        q_evt_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o
);
  logic [63:0] ticks_mem [StackDepth];
  logic [63:0] child_mem [StackDepth];
  logic [31:0] bytes_mem [StackDepth];

  bk_state_e   st_q, st_d;
  evt_t        ev_q;
  logic [DepthW-1:0] top_q, top_d;
  logic        leaf_q;
  logic [31:0] rep_cnt_q;
  logic [63:0] ticks_rd_q, child_rd_q;
  logic [31:0] bytes_rd_q;
  logic [63:0] child_par_q;
  logic [PtrW-1:0] f_idx;
  logic [63:0] prod_q;
  logic        neg_q;
  logic [63:0] quo_q, rem_q;
  logic [6:0]  bit_q;
  logic [31:0] div_q;
  logic [64:0] rem_sh;
  logic [63:0] interval, self_t;
  logic [31:0] mdelta;
  res_t        res_q;
  logic        ok_push, ok_pop, is_push;

  assign f_idx   = top_q[PtrW-1:0] - PtrW'(1);
  assign is_push = !ev_q.mode;
  assign ok_push = is_push && (top_q != DepthW'(StackDepth));
  assign ok_pop  = !is_push && (top_q != '0);
  assign q_ready_o   = (st_q == BK_IDLE);
  assign res_valid_o = (st_q == BK_OUT);
  assign res_o = res_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: if (q_valid_i) st_d = BK_READ;
      BK_READ: st_d = ok_pop ? BK_MUL : BK_FIN;
      BK_MUL:  st_d = BK_DIV;
      BK_DIV:  if (bit_q == 7'd0) st_d = BK_FIN;
      BK_FIN:  st_d = BK_OUT;
      BK_OUT:  if (res_ready_i) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  // Stack depth after the current event.
  always_comb begin
    top_d = top_q;
    if (ok_push) top_d = top_q + DepthW'(1);
    else if (ok_pop) top_d = top_q - DepthW'(1);
  end

  assign rem_sh   = {rem_q, quo_q[63]};
  assign interval = neg_q ? (~quo_q + 64'd1) : quo_q;
  assign self_t   = time_en_i ? (interval - child_rd_q) : 64'd0;
  assign mdelta   = (mem_en_i && ev_q.total_bytes != 32'd0) ?
                    (ev_q.total_bytes - bytes_rd_q) : 32'd0;

  // Frame stores, no reset.
  always_ff @(posedge clk_i) begin
    if (st_q == BK_READ) begin
      ticks_rd_q <= ticks_mem[f_idx];
      child_rd_q <= child_mem[f_idx];
      bytes_rd_q <= bytes_mem[f_idx];
      if (ok_push) begin
        if (time_en_i) begin
          ticks_mem[top_q[PtrW-1:0]] <= {1'b0, ev_q.timestamp};
          child_mem[top_q[PtrW-1:0]] <= 64'd0;
        end
        if (mem_en_i) bytes_mem[top_q[PtrW-1:0]] <= ev_q.total_bytes;
      end
    end
    // Add the inclusive interval to the parent frame, if there is one.
    if (st_q == BK_FIN && ok_pop && time_en_i && f_idx != '0)
      child_mem[f_idx - PtrW'(1)] <= child_par_q + interval;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_MUL) child_par_q <= child_mem[f_idx - PtrW'(1)];
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (st_q == BK_IDLE && q_valid_i) ev_q <= q_evt_i;
    unique case (st_q)
      BK_MUL: begin
        prod_q <= ({1'b0, ev_q.timestamp} - ticks_rd_q) * 64'(UsPerSecond);
        div_q  <= (freq_i == 32'd0) ? 32'd1 : freq_i;
      end
      BK_DIV: begin
        if (bit_q == 7'd64) begin
          neg_q <= prod_q[63];
          quo_q <= prod_q[63] ? (~prod_q + 64'd1) : prod_q;
          rem_q <= 64'd0;
        end else begin
          quo_q <= {quo_q[62:0], rem_sh >= {33'd0, div_q}};
          rem_q <= (rem_sh >= {33'd0, div_q}) ? 64'(rem_sh - {33'd0, div_q})
                                              : rem_sh[63:0];
        end
      end
      default: ;
    endcase
    if (st_q == BK_FIN) begin
      res_q.self_time <= '0;
      res_q.mem_delta <= '0;
      res_q.depth <= top_d;
      if (is_push) res_q.status <= ok_push ? ST_PUSHED : ST_OVERFLOW;
      else if (!ok_pop) res_q.status <= ST_UNDERFLOW;
      else begin
        res_q.self_time <= self_t;
        res_q.mem_delta <= mdelta;
        res_q.status <= ((self_t == 64'd0 || self_t[63]) && leaf_q) ? ST_DROPPED
                                                                   : ST_REPORTED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE; top_q <= '0; leaf_q <= 1'b0; rep_cnt_q <= '0; bit_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == BK_MUL) bit_q <= 7'd64;
      else if (st_q == BK_DIV && bit_q == 7'd64) bit_q <= 7'd63;
      else if (st_q == BK_DIV && bit_q != 7'd0) bit_q <= bit_q - 7'd1;
      if (st_q == BK_FIN) begin
        top_q <= top_d;
        if (ok_push) begin
          leaf_q <= 1'b1;
        end else if (ok_pop) begin
          leaf_q <= 1'b0;
          if (!((self_t == 64'd0 || self_t[63]) && leaf_q)) rep_cnt_q <= rep_cnt_q + 32'd1;
        end
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_top_range, top_q <= DepthW'(StackDepth), "stack pointer past depth")
  `ASSERT_CLK(a_out_hold, res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_q),
              "result changed while stalled")
  `ASSERT_CLK(a_ready_idle, q_ready_o |-> !res_valid_o, "accepting while result pending")
endmodule
